[design/rbsdf_pkg.sv]
// ---------------------------------------------------------------------------
// rbsdf_pkg
// Shared types and widths of the rounded box distance and normal block.
// ---------------------------------------------------------------------------
`default_nettype none

package rbsdf_pkg;

   // field widths
   localparam int PT_W        = 32;   // query coordinate
   localparam int CFG_W       = 31;   // extents and radius
   localparam int STEP_W      = 16;   // difference step
   localparam int CSR_IDX_W   = 3;
   localparam int NRM_W       = 18;   // normal component, Q1.16
   localparam int NORMAL_FRAC = 16;

   // datapath widths
   localparam int CRD_W       = 33;   // coordinate +/- step
   localparam int ABS_W       = 32;   // magnitude of a sample coordinate
   localparam int Q_W         = 34;   // |p| - half + radius
   localparam int O_W         = 33;   // max(q, 0)
   localparam int SQ_W        = 66;   // o squared
   localparam int ROOT_W      = 34;   // floor sqrt of the outside length
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int M_W         = 32;   // min(max q, 0)
   localparam int DIST_W      = 36;   // unsaturated distance
   localparam int G_W         = 18;   // central difference, |g| <= 2h
   localparam int MAG_W       = 17;
   localparam int LEN_W       = 18;   // gradient length
   localparam int GSUM_W      = 2 * LEN_W;
   localparam int QUO_W       = 17;   // normal magnitude, up to 1.0
   localparam int DVD_W       = QUO_W + LEN_W;
   localparam int NUM_SAMPLES = 7;    // center, then +/- along x, y, z

   // configuration register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_X       = 3'd0,
      CSR_HALF_Y       = 3'd1,
      CSR_HALF_Z       = 3'd2,
      CSR_ROUND_RADIUS = 3'd3,
      CSR_GRAD_STEP    = 3'd4
   } csr_index_type;

   // carried alongside the gradient length root
   typedef struct packed {
      logic signed [PT_W-1:0] dsat;
      logic [2:0]             sign;
      logic [2:0][MAG_W-1:0]  mag;
   } len_side_type;

   // carried alongside the x divider lane
   typedef struct packed {
      logic signed [PT_W-1:0] dsat;
      logic                   zero;
      logic                   sign;
   } div_side_type;

   // one result transaction
   typedef struct packed {
      logic signed [PT_W-1:0]  distance;
      logic signed [NRM_W-1:0] normal_x;
      logic signed [NRM_W-1:0] normal_y;
      logic signed [NRM_W-1:0] normal_z;
      logic                    zero_gradient;
   } rsp_type;

endpackage

`default_nettype wire

[design/rbsdf_if.sv]
// ---------------------------------------------------------------------------
// rbsdf_req_if / rbsdf_rsp_if
// Valid/ready channels for query points and results.
// ---------------------------------------------------------------------------
`default_nettype none

interface rbsdf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rbsdf_pkg::PT_W-1:0]   point_x;
   logic signed [rbsdf_pkg::PT_W-1:0]   point_y;
   logic signed [rbsdf_pkg::PT_W-1:0]   point_z;
   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

interface rbsdf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rbsdf_pkg::PT_W-1:0]   distance;
   logic signed [rbsdf_pkg::NRM_W-1:0]  normal_x;
   logic signed [rbsdf_pkg::NRM_W-1:0]  normal_y;
   logic signed [rbsdf_pkg::NRM_W-1:0]  normal_z;
   logic                                zero_gradient;
   modport source (output valid, output distance, output normal_x, output normal_y,
                   output normal_z, output zero_gradient, input ready);
   modport sink   (input valid, input distance, input normal_x, input normal_y,
                   input normal_z, input zero_gradient, output ready);
endinterface

`default_nettype wire

[design/rbsdf_sqrt.sv]
// ---------------------------------------------------------------------------
// rbsdf_sqrt
// Pipelined floor square root, one result bit per stage, with sideband.
// ---------------------------------------------------------------------------
`default_nettype none

module rbsdf_sqrt #(
   parameter int ROOT_W = 34,
   parameter int SIDE_W = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [2*ROOT_W-1:0]   in_rad,
   input  wire logic [SIDE_W-1:0]     in_side,
   output logic                       out_valid,
   output logic [ROOT_W-1:0]          out_root,
   output logic [SIDE_W-1:0]          out_side
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 1;

   logic [ROOT_W-1:0] vld_ff;
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [RAD_W-1:0]  rad_in  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   // one trial subtract per stage
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [RAD_W-1:0]  rad_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [REM_W:0]    rem_sh;
      logic [REM_W:0]    trial;
      logic [REM_W:0]    diff;
      logic              fits;

      if (k == 0) begin : g_first
         assign rad_prev  = in_rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      assign rem_sh     = {rem_prev[ROOT_W-1:0], rad_prev[RAD_W-1 -: 2]};
      assign trial      = {root_prev, 2'b01};
      assign diff       = rem_sh - trial;
      assign fits       = (rem_sh >= trial);
      assign rad_in[k]  = rad_prev << 2;
      assign rem_in[k]  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      assign root_in[k] = {root_prev[ROOT_W-2:0], fits};
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int k = 0; k < ROOT_W; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
         for (int k = 1; k < ROOT_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

`default_nettype wire

[design/rbsdf_div.sv]
// ---------------------------------------------------------------------------
// rbsdf_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// The quotient must fit QUO_W bits.
// ---------------------------------------------------------------------------
`default_nettype none

module rbsdf_div #(
   parameter int QUO_W  = 17,
   parameter int DIV_W  = 18,
   parameter int SIDE_W = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [QUO_W+DIV_W-1:0]  in_dividend,
   input  wire logic [DIV_W-1:0]        in_divisor,
   input  wire logic [SIDE_W-1:0]       in_side,
   output logic                         out_valid,
   output logic [QUO_W-1:0]             out_quo,
   output logic [SIDE_W-1:0]            out_side
);

   logic [QUO_W-1:0]  vld_ff;
   logic [DIV_W-1:0]  rem_ff  [QUO_W];
   logic [DIV_W-1:0]  rem_in  [QUO_W];
   logic [QUO_W-1:0]  low_ff  [QUO_W];
   logic [QUO_W-1:0]  low_in  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_in  [QUO_W];
   logic [DIV_W-1:0]  dsr_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   // one compare and subtract per stage
   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [DIV_W-1:0] rem_prev;
      logic [QUO_W-1:0] low_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [DIV_W-1:0] dsr_prev;
      logic [DIV_W:0]   trial;
      logic [DIV_W:0]   diff;
      logic             fits;

      if (k == 0) begin : g_first
         assign rem_prev = in_dividend[QUO_W+DIV_W-1 -: DIV_W];
         assign low_prev = in_dividend[QUO_W-1:0];
         assign quo_prev = '0;
         assign dsr_prev = in_divisor;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign dsr_prev = dsr_ff[k-1];
      end

      assign trial     = {rem_prev, low_prev[QUO_W-1]};
      assign diff      = trial - {1'b0, dsr_prev};
      assign fits      = (trial >= {1'b0, dsr_prev});
      assign rem_in[k] = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      assign low_in[k] = low_prev << 1;
      assign quo_in[k] = {quo_prev[QUO_W-2:0], fits};
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QUO_W-2:0], in_valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         dsr_ff[0]  <= in_divisor;
         side_ff[0] <= in_side;
         for (int k = 0; k < QUO_W; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
         end
         for (int k = 1; k < QUO_W; k++) begin
            dsr_ff[k]  <= dsr_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

`default_nettype wire

[design/round_box_sdf_distance_normal_top.sv]
// The pipeline holds 81 register stages, counting the output queue.
// Throughput: one query per cycle unless the output queue is full and the receiver is
// not ready; the 34-stage distance root, the 18-stage gradient length root and the
// 17-stage normal divider are all fully pipelined.
// A two-entry output queue lets the pipeline keep taking queries while results wait.
// Reset (synchronous): pipeline and queue empty, registers at their documented defaults.
// ---------------------------------------------------------------------------
// round_box_sdf_distance_normal_top
// Rounded box signed distance at a point plus its unit normal from central
// differences over seven distance samples.
// ---------------------------------------------------------------------------
`default_nettype none

module round_box_sdf_distance_normal_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   rbsdf_req_if.sink                               req_ch,
   rbsdf_rsp_if.source                             rsp_ch,
   input  wire logic                               csr_we,
   input  wire logic [rbsdf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rbsdf_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int PT_W    = rbsdf_pkg::PT_W;
   localparam int CFG_W   = rbsdf_pkg::CFG_W;
   localparam int STEP_W  = rbsdf_pkg::STEP_W;
   localparam int CRD_W   = rbsdf_pkg::CRD_W;
   localparam int ABS_W   = rbsdf_pkg::ABS_W;
   localparam int Q_W     = rbsdf_pkg::Q_W;
   localparam int O_W     = rbsdf_pkg::O_W;
   localparam int SQ_W    = rbsdf_pkg::SQ_W;
   localparam int ROOT_W  = rbsdf_pkg::ROOT_W;
   localparam int RAD_W   = rbsdf_pkg::RAD_W;
   localparam int M_W     = rbsdf_pkg::M_W;
   localparam int DIST_W  = rbsdf_pkg::DIST_W;
   localparam int G_W     = rbsdf_pkg::G_W;
   localparam int MAG_W   = rbsdf_pkg::MAG_W;
   localparam int LEN_W   = rbsdf_pkg::LEN_W;
   localparam int GSUM_W  = rbsdf_pkg::GSUM_W;
   localparam int QUO_W   = rbsdf_pkg::QUO_W;
   localparam int DVD_W   = rbsdf_pkg::DVD_W;
   localparam int NRM_W   = rbsdf_pkg::NRM_W;
   localparam int NFRAC   = rbsdf_pkg::NORMAL_FRAC;
   localparam int NS      = rbsdf_pkg::NUM_SAMPLES;

   localparam logic [CFG_W-1:0]  HALF_RESET = CFG_W'(64'd1 << FRAC_BITS);
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(66);
   localparam logic signed [DIST_W-1:0] DIST_MAX = DIST_W'(64'sd2147483647);
   localparam logic signed [DIST_W-1:0] DIST_MIN = -DIST_W'(64'sd2147483648);

   // which of center / plus / minus a sample takes on an axis
   function automatic int axis_tap(input int s, input int a);
      int tap;
      tap = 0;
      if (s == 2 * a + 1) tap = 1;
      if (s == 2 * a + 2) tap = 2;
      return tap;
   endfunction

   // -----------------------------------------------------------------------
   // configuration registers
   // -----------------------------------------------------------------------
   logic [CFG_W-1:0]  half_ff [3];
   logic [CFG_W-1:0]  radius_ff;
   logic [STEP_W-1:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff[0] <= HALF_RESET;
         half_ff[1] <= HALF_RESET;
         half_ff[2] <= HALF_RESET;
         radius_ff  <= '0;
         step_ff    <= STEP_RESET;
      end else if (csr_we) begin
         unique case (rbsdf_pkg::csr_index_type'(csr_index))
            rbsdf_pkg::CSR_HALF_X:       half_ff[0] <= csr_wdata;
            rbsdf_pkg::CSR_HALF_Y:       half_ff[1] <= csr_wdata;
            rbsdf_pkg::CSR_HALF_Z:       half_ff[2] <= csr_wdata;
            rbsdf_pkg::CSR_ROUND_RADIUS: radius_ff  <= csr_wdata;
            rbsdf_pkg::CSR_GRAD_STEP:    step_ff    <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // -----------------------------------------------------------------------
   // pipeline advance and output queue
   // -----------------------------------------------------------------------
   logic                 en;
   logic [1:0]           cnt_ff;
   logic                 wr_ff;
   logic                 rd_ff;
   rbsdf_pkg::rsp_type   queue_ff [2];
   rbsdf_pkg::rsp_type   push_data;
   logic                 push;
   logic                 pop;
   logic                 out_v;

   assign en           = (cnt_ff != 2'd2) || rsp_ch.ready;
   assign req_ch.ready = en;

   // -----------------------------------------------------------------------
   // stage 1: sample coordinates c, c + h, c - h
   // -----------------------------------------------------------------------
   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [CRD_W-1:0] crd_ff [3][3];
   logic signed [CRD_W-1:0] pt_ext [3];
   logic signed [CRD_W-1:0] step_ext;

   assign pt_ext[0] = CRD_W'(req_ch.point_x);
   assign pt_ext[1] = CRD_W'(req_ch.point_y);
   assign pt_ext[2] = CRD_W'(req_ch.point_z);
   assign step_ext  = $signed({{(CRD_W-STEP_W){1'b0}}, step_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            crd_ff[a][0] <= pt_ext[a];
            crd_ff[a][1] <= pt_ext[a] + step_ext;
            crd_ff[a][2] <= pt_ext[a] - step_ext;
         end
      end
   end

   // stage 2: magnitudes
   logic [ABS_W-1:0] abs_ff [3][3];
   logic [CRD_W-1:0] crd_neg [3][3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int i = 0; i < 3; i++) begin
            crd_neg[a][i] = -crd_ff[a][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < 3; i++) begin
               abs_ff[a][i] <= crd_ff[a][i][CRD_W-1] ? crd_neg[a][i][ABS_W-1:0]
                                                     : crd_ff[a][i][ABS_W-1:0];
            end
         end
      end
   end

   // stage 3: q = |p| - half + radius
   logic signed [Q_W-1:0] q_ff [3][3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < 3; i++) begin
               q_ff[a][i] <= $signed({{(Q_W-ABS_W){1'b0}}, abs_ff[a][i]})
                           - $signed({{(Q_W-CFG_W){1'b0}}, half_ff[a]})
                           + $signed({{(Q_W-CFG_W){1'b0}}, radius_ff});
            end
         end
      end
   end

   // stage 4: squares of the outside parts, inside term per sample
   logic [SQ_W-1:0]       sq_ff [3][3];
   logic signed [M_W-1:0] m4_ff [NS];
   logic signed [M_W-1:0] m4_in [NS];
   logic [O_W-1:0]        o_val [3][3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int i = 0; i < 3; i++) begin
            o_val[a][i] = q_ff[a][i][Q_W-1] ? '0 : q_ff[a][i][O_W-1:0];
         end
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_inside
      logic signed [Q_W-1:0] qa, qb, qc, mab, mx;
      assign qa  = q_ff[0][axis_tap(s, 0)];
      assign qb  = q_ff[1][axis_tap(s, 1)];
      assign qc  = q_ff[2][axis_tap(s, 2)];
      assign mab = (qa > qb) ? qa : qb;
      assign mx  = (qc > mab) ? qc : mab;
      assign m4_in[s] = (mx > 0) ? '0 : mx[M_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < 3; i++) begin
               sq_ff[a][i] <= o_val[a][i] * o_val[a][i];
            end
         end
         for (int s = 0; s < NS; s++) begin
            m4_ff[s] <= m4_in[s];
         end
      end
   end

   // stage 5: sum of squares per sample
   logic [RAD_W-1:0]      rad_ff [NS];
   logic [RAD_W-1:0]      rad_in [NS];
   logic signed [M_W-1:0] m5_ff  [NS];

   for (genvar s = 0; s < NS; s++) begin : g_sum
      assign rad_in[s] = RAD_W'(sq_ff[0][axis_tap(s, 0)])
                       + RAD_W'(sq_ff[1][axis_tap(s, 1)])
                       + RAD_W'(sq_ff[2][axis_tap(s, 2)]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NS; s++) begin
            rad_ff[s] <= rad_in[s];
            m5_ff[s]  <= m4_ff[s];
         end
      end
   end

   // valid chain through the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_ch.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // -----------------------------------------------------------------------
   // outside length roots, one unit per sample
   // -----------------------------------------------------------------------
   logic                  dv;
   logic [ROOT_W-1:0]     root_o [NS];
   logic [M_W-1:0]        m_o    [NS];

   rbsdf_sqrt #(.ROOT_W(ROOT_W), .SIDE_W(M_W)) u_root0 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v5_ff), .in_rad(rad_ff[0]), .in_side(m5_ff[0]),
      .out_valid(dv), .out_root(root_o[0]), .out_side(m_o[0])
   );

   for (genvar s = 1; s < NS; s++) begin : g_root
      rbsdf_sqrt #(.ROOT_W(ROOT_W), .SIDE_W(M_W)) u_root (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(v5_ff), .in_rad(rad_ff[s]), .in_side(m5_ff[s]),
         .out_valid(), .out_root(root_o[s]), .out_side(m_o[s])
      );
   end

   // stage 6: distances
   logic                     v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic signed [DIST_W-1:0] dist_ff [NS];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NS; s++) begin
            dist_ff[s] <= $signed({{(DIST_W-ROOT_W){1'b0}}, root_o[s]})
                        + DIST_W'($signed(m_o[s]))
                        - $signed({{(DIST_W-CFG_W){1'b0}}, radius_ff});
         end
      end
   end

   // stage 7: differences and saturated distance
   logic signed [G_W-1:0]    g_ff [3];
   logic signed [DIST_W-1:0] g_full [3];
   logic signed [PT_W-1:0]   dsat7_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         g_full[a] = dist_ff[2 * a + 1] - dist_ff[2 * a + 2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            g_ff[a] <= g_full[a][G_W-1:0];
         end
         if (dist_ff[0] > DIST_MAX) begin
            dsat7_ff <= DIST_MAX[PT_W-1:0];
         end else if (dist_ff[0] < DIST_MIN) begin
            dsat7_ff <= DIST_MIN[PT_W-1:0];
         end else begin
            dsat7_ff <= dist_ff[0][PT_W-1:0];
         end
      end
   end

   // stage 8: sign and magnitude of the gradient
   logic [2:0]             sign8_ff;
   logic [MAG_W-1:0]       mag8_ff [3];
   logic signed [PT_W-1:0] dsat8_ff;
   logic [G_W-1:0]         g_neg [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         g_neg[a] = -g_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            sign8_ff[a] <= g_ff[a][G_W-1];
            mag8_ff[a]  <= g_ff[a][G_W-1] ? g_neg[a][MAG_W-1:0] : g_ff[a][MAG_W-1:0];
         end
         dsat8_ff <= dsat7_ff;
      end
   end

   // stage 9: squares of the gradient
   logic [2*MAG_W-1:0]     gsq_ff [3];
   logic [2:0]             sign9_ff;
   logic [MAG_W-1:0]       mag9_ff [3];
   logic signed [PT_W-1:0] dsat9_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            gsq_ff[a]  <= mag8_ff[a] * mag8_ff[a];
            mag9_ff[a] <= mag8_ff[a];
         end
         sign9_ff <= sign8_ff;
         dsat9_ff <= dsat8_ff;
      end
   end

   // stage 10: squared gradient length
   logic [GSUM_W-1:0]       gsum_ff;
   rbsdf_pkg::len_side_type lside_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         gsum_ff <= GSUM_W'(gsq_ff[0]) + GSUM_W'(gsq_ff[1]) + GSUM_W'(gsq_ff[2]);
         lside_ff.dsat   <= dsat9_ff;
         lside_ff.sign   <= sign9_ff;
         lside_ff.mag[0] <= mag9_ff[0];
         lside_ff.mag[1] <= mag9_ff[1];
         lside_ff.mag[2] <= mag9_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else if (en) begin
         v6_ff  <= dv;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
      end
   end

   // -----------------------------------------------------------------------
   // gradient length root
   // -----------------------------------------------------------------------
   logic                    lv;
   logic [LEN_W-1:0]        len_o;
   rbsdf_pkg::len_side_type lside_o;

   rbsdf_sqrt #(.ROOT_W(LEN_W), .SIDE_W($bits(rbsdf_pkg::len_side_type))) u_len (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v10_ff), .in_rad(gsum_ff), .in_side(lside_ff),
      .out_valid(lv), .out_root(len_o), .out_side(lside_o)
   );

   // stage 11: rounded dividends mag * 2^16 + len / 2
   logic                   v11_ff;
   logic [DVD_W-1:0]       dvd_ff [3];
   logic [LEN_W-1:0]       len_ff;
   rbsdf_pkg::div_side_type dside_ff;
   logic [2:0]             sign11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else if (en) begin
         v11_ff <= lv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            dvd_ff[a] <= DVD_W'({lside_o.mag[a], {NFRAC{1'b0}}}) + DVD_W'(len_o >> 1);
         end
         len_ff         <= len_o;
         sign11_ff      <= lside_o.sign;
         dside_ff.dsat  <= lside_o.dsat;
         dside_ff.zero  <= (len_o == '0);
         dside_ff.sign  <= lside_o.sign[0];
      end
   end

   // -----------------------------------------------------------------------
   // normal dividers
   // -----------------------------------------------------------------------
   logic                    ov;
   logic [QUO_W-1:0]        quo_o [3];
   rbsdf_pkg::div_side_type dside_o;
   logic                    sign_y_o;
   logic                    sign_z_o;

   rbsdf_div #(.QUO_W(QUO_W), .DIV_W(LEN_W),
               .SIDE_W($bits(rbsdf_pkg::div_side_type))) u_div_x (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v11_ff), .in_dividend(dvd_ff[0]), .in_divisor(len_ff),
      .in_side(dside_ff),
      .out_valid(ov), .out_quo(quo_o[0]), .out_side(dside_o)
   );

   rbsdf_div #(.QUO_W(QUO_W), .DIV_W(LEN_W), .SIDE_W(1)) u_div_y (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v11_ff), .in_dividend(dvd_ff[1]), .in_divisor(len_ff),
      .in_side(sign11_ff[1]),
      .out_valid(), .out_quo(quo_o[1]), .out_side(sign_y_o)
   );

   rbsdf_div #(.QUO_W(QUO_W), .DIV_W(LEN_W), .SIDE_W(1)) u_div_z (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v11_ff), .in_dividend(dvd_ff[2]), .in_divisor(len_ff),
      .in_side(sign11_ff[2]),
      .out_valid(), .out_quo(quo_o[2]), .out_side(sign_z_o)
   );

   // -----------------------------------------------------------------------
   // result assembly: apply signs, force zero normal on a flat gradient
   // -----------------------------------------------------------------------
   logic [2:0]              sgn_o;
   logic signed [NRM_W-1:0] nrm [3];

   assign sgn_o = {sign_z_o, sign_y_o, dside_o.sign};

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (dside_o.zero) begin
            nrm[a] = '0;
         end else if (sgn_o[a]) begin
            nrm[a] = -$signed({{(NRM_W-QUO_W){1'b0}}, quo_o[a]});
         end else begin
            nrm[a] = $signed({{(NRM_W-QUO_W){1'b0}}, quo_o[a]});
         end
      end
   end

   assign push_data.distance      = dside_o.dsat;
   assign push_data.normal_x      = nrm[0];
   assign push_data.normal_y      = nrm[1];
   assign push_data.normal_z      = nrm[2];
   assign push_data.zero_gradient = dside_o.zero;

   // -----------------------------------------------------------------------
   // output queue, two entries
   // -----------------------------------------------------------------------
   assign out_v = (cnt_ff != 2'd0);
   assign push  = en && ov;
   assign pop   = out_v && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ff] <= push_data;
      end
   end

   assign rsp_ch.valid         = out_v;
   assign rsp_ch.distance      = queue_ff[rd_ff].distance;
   assign rsp_ch.normal_x      = queue_ff[rd_ff].normal_x;
   assign rsp_ch.normal_y      = queue_ff[rd_ff].normal_y;
   assign rsp_ch.normal_z      = queue_ff[rd_ff].normal_z;
   assign rsp_ch.zero_gradient = queue_ff[rd_ff].zero_gradient;

endmodule

`default_nettype wire

[tb/sv/round_box_sdf_distance_normal_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// round_box_sdf_distance_normal_top_tb
// Self-checking bench: query points are sent over the request channel and
// each result is checked against a local rounded box distance and normal
// predictor. Box shape and gradient step are changed between test phases.
// ---------------------------------------------------------------------------
`default_nettype none

module round_box_sdf_distance_normal_top_tb;

   localparam int  WATCHDOG_LIMIT = 20000;
   localparam int  DRAIN_CYCLES   = 100;
   localparam longint ONE         = 65536;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_we    = 1'b0;
   logic [rbsdf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rbsdf_pkg::CFG_W-1:0]     csr_wdata = '0;

   rbsdf_req_if req_ch ();
   rbsdf_rsp_if rsp_ch ();

   round_box_sdf_distance_normal_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // predictor copy of the configuration
   longint box_hx, box_hy, box_hz, box_radius, grad_step;

   rbsdf_pkg::rsp_type expected_results[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      no_gaps     = 1'b0;
   int      hold_requests = 0;

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.point_z = '0;
      rsp_ch.ready   = 1'b0;
   end

   // floor(sqrt(a*a + b*b + c*c))
   function automatic longint root_of_squares(longint unsigned a, longint unsigned b,
                                              longint unsigned c);
      logic [127:0] sum;
      logic [127:0] cand;
      longint unsigned r;
      sum = {64'd0, a} * {64'd0, a} + {64'd0, b} * {64'd0, b} + {64'd0, c} * {64'd0, c};
      r = 0;
      for (int bitpos = 36; bitpos >= 0; bitpos--) begin
         cand = {64'd0, r | (64'd1 << bitpos)};
         if (cand * cand <= sum) r = r | (64'd1 << bitpos);
      end
      return longint'(r);
   endfunction

   function automatic longint axis_offset(longint p, longint half);
      return (p < 0 ? -p : p) - half + box_radius;
   endfunction

   function automatic longint rounded_box_distance(longint x, longint y, longint z);
      longint qx, qy, qz, m;
      qx = axis_offset(x, box_hx);
      qy = axis_offset(y, box_hy);
      qz = axis_offset(z, box_hz);
      m = (qx > qy) ? qx : qy;
      if (qz > m) m = qz;
      if (m > 0) m = 0;
      return root_of_squares(qx > 0 ? qx : 0, qy > 0 ? qy : 0, qz > 0 ? qz : 0)
             + m - box_radius;
   endfunction

   function automatic logic signed [rbsdf_pkg::NRM_W-1:0] unit_component(longint g,
                                                                         longint len);
      longint a, n;
      a = (g < 0) ? -g : g;
      n = (a * ONE + len / 2) / len;
      if (n > ONE) n = ONE;
      if (g < 0) n = -n;
      return n[rbsdf_pkg::NRM_W-1:0];
   endfunction

   function automatic rbsdf_pkg::rsp_type predict_surface(longint x, longint y, longint z);
      rbsdf_pkg::rsp_type r;
      longint d, gx, gy, gz, len;
      d  = rounded_box_distance(x, y, z);
      gx = rounded_box_distance(x + grad_step, y, z) - rounded_box_distance(x - grad_step, y, z);
      gy = rounded_box_distance(x, y + grad_step, z) - rounded_box_distance(x, y - grad_step, z);
      gz = rounded_box_distance(x, y, z + grad_step) - rounded_box_distance(x, y, z - grad_step);
      len = root_of_squares(gx < 0 ? -gx : gx, gy < 0 ? -gy : gy, gz < 0 ? -gz : gz);
      if (d > 64'sd2147483647)  d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      r.distance = d[rbsdf_pkg::PT_W-1:0];
      if (len == 0) begin
         r.normal_x = '0;
         r.normal_y = '0;
         r.normal_z = '0;
         r.zero_gradient = 1'b1;
      end else begin
         r.normal_x = unit_component(gx, len);
         r.normal_y = unit_component(gy, len);
         r.normal_z = unit_component(gz, len);
         r.zero_gradient = 1'b0;
      end
      return r;
   endfunction

   // write all five registers back to back while the block is idle
   task automatic set_box(longint hx, longint hy, longint hz, longint rad, longint step);
      longint vals[5];
      rbsdf_pkg::csr_index_type idx[5];
      vals = '{hx, hy, hz, rad, step};
      idx  = '{rbsdf_pkg::CSR_HALF_X, rbsdf_pkg::CSR_HALF_Y, rbsdf_pkg::CSR_HALF_Z,
               rbsdf_pkg::CSR_ROUND_RADIUS, rbsdf_pkg::CSR_GRAD_STEP};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i][rbsdf_pkg::CFG_W-1:0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      box_hx = hx & 64'h7FFF_FFFF;
      box_hy = hy & 64'h7FFF_FFFF;
      box_hz = hz & 64'h7FFF_FFFF;
      box_radius = rad & 64'h7FFF_FFFF;
      grad_step = step & 64'hFFFF;
   endtask

   // send one query transaction; valid stays high into the next call
   task automatic send_point(logic signed [rbsdf_pkg::PT_W-1:0] x,
                             logic signed [rbsdf_pkg::PT_W-1:0] y,
                             logic signed [rbsdf_pkg::PT_W-1:0] z);
      if (!no_gaps && $urandom_range(99) < 11) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (!no_gaps && $urandom_range(99) < 11);
      end
      req_ch.valid   <= 1'b1;
      req_ch.point_x <= x;
      req_ch.point_y <= y;
      req_ch.point_z <= z;
      do @(posedge clock); while (!req_ch.ready);
      expected_results.push_back(predict_surface(x, y, z));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // coordinate within three half extents plus a margin most of the time, else near a face, at a limit or anywhere
   function automatic logic signed [rbsdf_pkg::PT_W-1:0] pick_coord(longint half);
      longint unsigned span;
      longint v;
      case ($urandom_range(7))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2: begin
            v = ($urandom_range(1) ? half : -half) + $signed($urandom_range(400)) - 200;
            return v[rbsdf_pkg::PT_W-1:0];
         end
         default: begin
            span = half * 3 + 1000;
            if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
            v = longint'({$urandom, $urandom} % (2 * span + 1)) - longint'(span);
            return v[rbsdf_pkg::PT_W-1:0];
         end
      endcase
   endfunction

   // ---------------- tests ----------------
   task automatic test_default_box();
      send_point(0, 0, 0);                    // center: symmetric, zero gradient
      send_point(32'sh0002_0000, 0, 0);
      send_point(0, -32'sh0002_0000, 0);
      send_point(0, 0, 32'sh0000_8000);
      send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_point(32'sh7FFF_FFFF, 0, 32'sh8000_0000);
      send_point(-1, 1, -1);
      wait_drained();
   endtask

   task automatic test_extreme_boxes();
      // huge box and radius: distance reaches minus the radius at the center, just above the low limit
      set_box(64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 65535);
      send_point(0, 0, 0);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      send_point(32'sh4000_0000, 32'sh1234_5678, -32'sh0765_4321);
      wait_drained();
      // degenerate box: distance saturates high at far corners
      set_box(0, 0, 0, 0, 1);
      send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_point(0, 0, 0);
      send_point(1, 0, 0);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
      wait_drained();
      // zero step: every difference vanishes
      set_box(ONE, 2 * ONE, 3 * ONE, ONE / 2, 0);
      send_point(32'sh0003_0000, 32'sh0001_0000, 0);
      send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 5);
      wait_drained();
      // radius larger than the smallest half extent
      set_box(ONE / 4, 4 * ONE, 4 * ONE, 2 * ONE, 66);
      send_point(32'sh0001_0000, 0, 0);
      send_point(0, 32'sh0005_0000, 32'sh0005_0000);
      send_point(-32'sh0000_4000, 32'sh0004_0000, -32'sh0004_0000);
      wait_drained();
   endtask

   task automatic test_stalled_output();
      set_box(ONE, ONE, ONE, ONE / 8, 66);
      no_gaps = 1'b1;
      hold_requests++;
      for (int i = 0; i < 200; i++)
         send_point(pick_coord(box_hx), pick_coord(box_hy), pick_coord(box_hz));
      no_gaps = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_boxes(int phases, int per_phase);
      longint hx, hy, hz, rad, mn;
      for (int p = 0; p < phases; p++) begin
         hx = $urandom_range(3) == 0 ? longint'($urandom) & 64'h7FFF_FFFF
                                     : $urandom_range(8 * ONE);
         hy = $urandom_range(3) == 0 ? longint'($urandom) & 64'h7FFF_FFFF
                                     : $urandom_range(8 * ONE);
         hz = $urandom_range(8 * ONE);
         mn = hx < hy ? hx : hy;
         if (hz < mn) mn = hz;
         rad = $urandom_range(5) == 0 ? $urandom_range(4 * ONE) : $urandom_range(mn);
         set_box(hx, hy, hz, rad,
                 $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(1, 300));
         no_gaps = (p == 1);
         for (int i = 0; i < per_phase; i++)
            send_point(pick_coord(box_hx), pick_coord(box_hy), pick_coord(box_hz));
         no_gaps = 1'b0;
         wait_drained();
      end
   endtask

   // ---------------- result checking ----------------
   always @(posedge clock) begin
      rbsdf_pkg::rsp_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transaction, distance %0d", rsp_ch.distance);
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_ch.distance !== exp_r.distance) begin
               $error("distance expected %0d actual %0d", exp_r.distance, rsp_ch.distance);
               error_count++;
            end
            if (rsp_ch.normal_x !== exp_r.normal_x) begin
               $error("normal_x expected %0d actual %0d", exp_r.normal_x, rsp_ch.normal_x);
               error_count++;
            end
            if (rsp_ch.normal_y !== exp_r.normal_y) begin
               $error("normal_y expected %0d actual %0d", exp_r.normal_y, rsp_ch.normal_y);
               error_count++;
            end
            if (rsp_ch.normal_z !== exp_r.normal_z) begin
               $error("normal_z expected %0d actual %0d", exp_r.normal_z, rsp_ch.normal_z);
               error_count++;
            end
            if (rsp_ch.zero_gradient !== exp_r.zero_gradient) begin
               $error("zero_gradient expected %0b actual %0b",
                      exp_r.zero_gradient, rsp_ch.zero_gradient);
               error_count++;
            end
         end
      end
   end

   // receiver: random idling, plus a long hold counted here on request
   always @(posedge clock) begin
      static int hold_left = 0;
      static int holds_seen = 0;
      if (holds_seen != hold_requests) begin
         holds_seen = hold_requests;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 11);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[round_box_sdf_distance_normal_top] ERROR");
         $finish;
      end
   end

   initial begin
      box_hx = ONE;
      box_hy = ONE;
      box_hz = ONE;
      box_radius = 0;
      grad_step = 66;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_box();
      test_extreme_boxes();
      test_stalled_output();
      test_random_boxes(6, 200);
      if (error_count == 0)
         $display("[round_box_sdf_distance_normal_top] OK");
      else
         $display("[round_box_sdf_distance_normal_top] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
design/rbsdf_pkg.sv
design/rbsdf_if.sv
design/rbsdf_sqrt.sv
design/rbsdf_div.sv
design/round_box_sdf_distance_normal_top.sv
tb/sv/round_box_sdf_distance_normal_top_tb.sv
